// ===== src/u2a_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u2a_pkg: shared types and helpers for the UTF-8 to ASCII transliterator
// Result item type, per-item step record and the code point mapping table.
// ----------------------------------------------------------------------------
package u2a_pkg;

	localparam int unsigned QueueDepth = 4;

	localparam logic [7:0] CAP_RESET = 8'd64;

	localparam logic [6:0] CH_APOS  = 7'h27;
	localparam logic [6:0] CH_QUOTE = 7'h22;
	localparam logic [6:0] CH_DASH  = 7'h2D;
	localparam logic [6:0] CH_DOT   = 7'h2E;
	localparam logic [6:0] CH_UNK   = 7'h3F;

	typedef struct packed {
		logic [6:0] ch;
		logic       is_end;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} step_t;

	function automatic logic [6:0] map_code(input logic [20:0] cp);
		logic [6:0] ch;
		unique case (cp)
			21'h02018, 21'h02019: ch = CH_APOS;
			21'h0201C, 21'h0201D: ch = CH_QUOTE;
			21'h02013, 21'h02014: ch = CH_DASH;
			21'h02026:            ch = CH_DOT;
			default:              ch = CH_UNK;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

// ===== src/u2a_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u2a_decode: UTF-8 sequence decoder and capacity tracker
// Holds the per-string state and turns one registered byte into up to two
// result items.
// ----------------------------------------------------------------------------
module u2a_decode (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              fire,
	input  wire  [7:0]       byte_s1,
	input  wire  [7:0]       cap,
	output u2a_pkg::step_t   step
);
	import u2a_pkg::*;

	logic [7:0]  cnt_q, nxt_cnt, cnt_inc, limit;
	logic [20:0] acc_q, nxt_acc, acc_shift;
	logic [1:0]  pend_q, nxt_pend;
	logic        closed_q, nxt_closed;
	logic        at_limit, cont, emit, clear;
	logic [6:0]  emit_ch;

	always_comb begin
		nxt_cnt    = cnt_q;
		nxt_acc    = acc_q;
		nxt_pend   = pend_q;
		nxt_closed = closed_q;
		step       = '0;
		emit       = 1'b0;
		emit_ch    = '0;
		clear      = 1'b0;
		limit      = (cap == 8'd0) ? 8'd0 : cap - 8'd1;
		at_limit   = cnt_q >= limit;
		cont       = byte_s1[7:6] == 2'b10;
		acc_shift  = {acc_q[14:0], byte_s1[5:0]};
		cnt_inc    = cnt_q + 8'd1;
		priority if (closed_q) begin
			clear = byte_s1 == 8'd0;
		end else if (at_limit) begin
			step.n      = 2'd1;
			step.r0     = '{ch: '0, is_end: 1'b1};
			nxt_closed  = 1'b1;
			nxt_acc     = '0;
			nxt_pend    = '0;
			clear       = byte_s1 == 8'd0;
		end else if (pend_q != 2'd0 && cont) begin
			nxt_acc  = acc_shift;
			nxt_pend = pend_q - 2'd1;
			if (pend_q == 2'd1) begin
				emit    = 1'b1;
				emit_ch = map_code(acc_shift);
				nxt_acc = '0;
			end
		end else begin
			nxt_acc  = '0;
			nxt_pend = '0;
			priority if (byte_s1 == 8'd0) begin
				step.n  = 2'd1;
				step.r0 = '{ch: '0, is_end: 1'b1};
				clear   = 1'b1;
			end else if (!byte_s1[7]) begin
				emit    = 1'b1;
				emit_ch = byte_s1[6:0];
			end else if (byte_s1[7:5] == 3'b110) begin
				nxt_acc  = {16'd0, byte_s1[4:0]};
				nxt_pend = 2'd1;
			end else if (byte_s1[7:4] == 4'b1110) begin
				nxt_acc  = {17'd0, byte_s1[3:0]};
				nxt_pend = 2'd2;
			end else if (byte_s1[7:3] == 5'b11110) begin
				nxt_acc  = {18'd0, byte_s1[2:0]};
				nxt_pend = 2'd3;
			end else begin
				// stray byte: dropped
				nxt_pend = 2'd0;
			end
		end
		if (emit) begin
			step.n  = 2'd1;
			step.r0 = '{ch: emit_ch, is_end: 1'b0};
			nxt_cnt = cnt_inc;
			if (cnt_inc >= limit) begin
				step.n     = 2'd2;
				step.r1    = '{ch: '0, is_end: 1'b1};
				nxt_closed = 1'b1;
			end
		end
		if (clear) begin
			nxt_cnt    = '0;
			nxt_acc    = '0;
			nxt_pend   = '0;
			nxt_closed = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			acc_q    <= '0;
			pend_q   <= '0;
			closed_q <= 1'b0;
		end else if (fire) begin
			cnt_q    <= nxt_cnt;
			acc_q    <= nxt_acc;
			pend_q   <= nxt_pend;
			closed_q <= nxt_closed;
		end
	end

`ifndef SYNTH
	a_closed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && closed_q |-> step.n == 2'd0)
		else $error("item produced after terminator");
	a_n_range: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> step.n != 2'd3)
		else $error("too many results for one item");
	a_pair_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && step.n == 2'd2 |=> closed_q)
		else $error("terminator pair did not close string");
`endif

endmodule
`default_nettype wire

// ===== src/u2a_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u2a_outq: result queue
// Small queue taking up to two result items per cycle while it has room and giving one while out_stall is low.
// ----------------------------------------------------------------------------
module u2a_outq (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  u2a_pkg::step_t   step,
	output logic             room,
	output logic             out_valid,
	input  wire              out_stall,
	output logic [6:0]       ascii_char,
	output logic             is_end
);
	import u2a_pkg::*;

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	res_t            mem_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q, n_push;
	logic            pop;

	assign out_valid  = cnt_q != '0;
	assign pop        = out_valid && !out_stall;
	assign room       = cnt_q <= CntW'(QueueDepth - 2);
	assign n_push     = push ? CntW'(step.n) : '0;
	assign ascii_char = mem_q[rd_q].ch;
	assign is_end     = mem_q[rd_q].is_end;

	always_ff @(posedge clk) begin
		if (push && step.n != 2'd0)
			mem_q[wr_q] <= step.r0;
		if (push && step.n == 2'd2)
			mem_q[wr_q + PtrW'(1)] <= step.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PtrW'(n_push);
			rd_q  <= rd_q + PtrW'(pop);
			cnt_q <= cnt_q + n_push - CntW'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(QueueDepth))
		else $error("result queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> room)
		else $error("push without room");
	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		PtrW'(wr_q - rd_q) == PtrW'(cnt_q))
		else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// ===== src/utf8_to_ascii_transliterator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_ascii_transliterator: UTF-8 byte stream to ASCII characters
// Usage:
//  Input channel (in_valid, in_stall, in_byte) takes one UTF-8 byte per item;
//  a zero byte ends the string. Output channel (out_valid, out_stall,
//  ascii_char, is_end) gives ASCII characters and one terminator item
//  (is_end = 1, ascii_char = 0) per string. A byte may cause zero, one or
//  two result items.
//  Throughput: one byte per cycle while the receiver keeps up; the four-entry
//  result queue sets the rate when two results follow one byte.
//  Path: an accepted byte is held in the input register, then decoded into
//  the result queue, whose head drives the output.
//  A stalled receiver fills the queue; the input register then holds its byte
//  and in_stall rises until two entries are free again.
//  cfg_valid/cfg_ready/cfg_data write out_capacity (terminator included);
//  cfg_ready is always high. Write only while the block is idle.
//  Reset clears the string state and queue and sets out_capacity to 64.
// ----------------------------------------------------------------------------
module utf8_to_ascii_transliterator (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] in_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [6:0] ascii_char,
	output logic       is_end,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [7:0] cfg_data
);
	import u2a_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic [7:0] cap_q;
	logic       room, fire;
	step_t      step;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && room;
	assign in_stall  = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= CAP_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				cap_q <= cfg_data;
			if (!in_stall)
				valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= in_byte;
	end

	u2a_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.cap     (cap_q),
		.step    (step)
	);

	u2a_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fire),
		.step       (step),
		.room       (room),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ascii_char (ascii_char),
		.is_end     (is_end)
	);

`ifndef SYNTH
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(byte_s1))
		else $error("held byte lost");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("stall without pending byte");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ascii_char) && $stable(is_end))
		else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for utf8_to_ascii_transliterator
// Feeds UTF-8 byte items through the valid/stall input channel, predicts the
// ASCII items of each accepted byte with a behavioral decoder of its own or
// from typed directed rows, and checks every output item in order. Directed
// bytes come first, then random phases of mostly well-formed strings under
// changing out_capacity, random stalls on both sides and a long receiver hold.
// ----------------------------------------------------------------------------
module tb;
	import u2a_pkg::*;

	localparam int   CYCLE_LIMIT = 800000;
	localparam int   DRAIN_MAX   = 100000;
	localparam int   SETTLE      = 6;
	localparam int   LONG_HOLD   = 80;
	localparam int   N_PHASES    = 10;
	localparam int   PHASE_ITEMS = 95;
	localparam int   HOLD_PHASE  = 4;
	localparam int   DRAIN_PHASE = 6;
	localparam res_t END_ITEM    = '{ch: 7'h00, is_end: 1'b1};
	localparam res_t NO_ITEM     = '0;

	localparam logic [20:0] PUNCT_CPS [0:6] = '{
		21'h02018, 21'h02019, 21'h0201C, 21'h0201D, 21'h02013, 21'h02014, 21'h02026
	};

	typedef struct packed {
		logic       cfg;   // row writes out_capacity
		logic [7:0] val;
		logic       typed; // expected items given in the row
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} drow_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_stall;
	logic [6:0] ascii_char;
	logic       is_end;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	// decoder state mirrored by the bench
	logic [7:0]  cap_q;
	logic [7:0]  n_emitted;
	logic [20:0] cp_acc;
	logic [1:0]  cont_left;
	logic        str_closed;
	res_t        step_out[$];
	res_t        expected_chars[$];
	logic [7:0]  tok_bytes[$];

	int n_fail    = 0;
	int cycles    = 0;
	bit tx_quiet  = 1'b0;
	bit rx_quiet  = 1'b0;
	bit hold_long = 1'b0;

	utf8_to_ascii_transliterator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ascii_char(ascii_char),
		.is_end    (is_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// ---------------- decoder model ----------------

	function automatic logic [7:0] char_limit();
		return (cap_q == 8'd0) ? 8'd0 : cap_q - 8'd1;
	endfunction

	function automatic logic [6:0] fold_code(input logic [20:0] cp);
		case (cp)
			21'h02018, 21'h02019: return CH_APOS;
			21'h0201C, 21'h0201D: return CH_QUOTE;
			21'h02013, 21'h02014: return CH_DASH;
			21'h02026:            return CH_DOT;
			default:              return CH_UNK;
		endcase
	endfunction

	task automatic clear_string();
		n_emitted  = '0;
		cp_acc     = '0;
		cont_left  = '0;
		str_closed = 1'b0;
	endtask

	task automatic put_char(input logic [6:0] ch);
		step_out.push_back('{ch: ch, is_end: 1'b0});
		n_emitted = n_emitted + 8'd1;
		if (n_emitted >= char_limit()) begin
			step_out.push_back(END_ITEM);
			str_closed = 1'b1;
		end
	endtask

	task automatic translit_step(input logic [7:0] b);
		step_out.delete();
		if (str_closed) begin
			if (b == 8'h00)
				clear_string();
		end else if (n_emitted >= char_limit()) begin
			// over capacity: close at once
			step_out.push_back(END_ITEM);
			if (b == 8'h00) begin
				clear_string();
			end else begin
				str_closed = 1'b1;
				cp_acc     = '0;
				cont_left  = '0;
			end
		end else if (cont_left != 2'd0 && b[7:6] == 2'b10) begin
			cp_acc    = {cp_acc[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				put_char(fold_code(cp_acc));
				cp_acc = '0;
			end
		end else begin
			cp_acc    = '0;
			cont_left = '0;
			if (b == 8'h00) begin
				step_out.push_back(END_ITEM);
				clear_string();
			end else if (!b[7]) begin
				put_char(b[6:0]);
			end else if (b[7:5] == 3'b110) begin
				cp_acc    = {16'd0, b[4:0]};
				cont_left = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				cp_acc    = {17'd0, b[3:0]};
				cont_left = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				cp_acc    = {18'd0, b[2:0]};
				cont_left = 2'd3;
			end
		end
	endtask

	// ---------------- output checker ----------------

	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected item ascii_char %h is_end %b",
					$time, ascii_char, is_end);
				n_fail++;
			end else begin
				want = expected_chars.pop_front();
				if (ascii_char !== want.ch) begin
					$display("%0t: ascii_char expected %h, got %h", $time, want.ch, ascii_char);
					n_fail++;
				end
				if (is_end !== want.is_end) begin
					$display("%0t: is_end expected %b, got %b", $time, want.is_end, is_end);
					n_fail++;
				end
			end
		end
	end

	// ---------------- receiver ----------------

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15)
			return $urandom_range(1, 3);
		else if (r < 19)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				hold_long = 1'b0;
			end else if (rx_quiet || $urandom_range(0, 3) != 0) begin
				out_stall <= 1'b0;
				@(negedge clk);
			end else begin
				out_stall <= 1'b1;
				repeat (gap_len()) @(negedge clk);
			end
		end
	end

	// ---------------- sender ----------------

	function automatic int tx_gap();
		if (tx_quiet || $urandom_range(0, 9) < 6)
			return 0;
		return gap_len();
	endfunction

	function automatic drow_t byte_row(input logic [7:0] v);
		drow_t r;
		r     = '0;
		r.val = v;
		return r;
	endfunction

	function automatic drow_t known_row(input logic [7:0] v, input logic [1:0] n,
			input res_t r0, input res_t r1);
		drow_t r;
		r       = '0;
		r.val   = v;
		r.typed = 1'b1;
		r.n     = n;
		r.r0    = r0;
		r.r1    = r1;
		return r;
	endfunction

	function automatic drow_t cap_row(input logic [7:0] v);
		drow_t r;
		r     = '0;
		r.cfg = 1'b1;
		r.val = v;
		return r;
	endfunction

	// called and returns at a falling edge
	task automatic send_byte(input drow_t row, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= row.val;
		do @(posedge clk); while (in_stall);
		translit_step(row.val);
		if (row.typed) begin
			if (row.n > 2'd0)
				expected_chars.push_back(row.r0);
			if (row.n > 2'd1)
				expected_chars.push_back(row.r1);
		end else begin
			foreach (step_out[i])
				expected_chars.push_back(step_out[i]);
		end
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_cap(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cap_q = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic gen_token();
		int          sel;
		int          len;
		int          n_cont;
		logic [20:0] cp;
		tok_bytes.delete();
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			tok_bytes.push_back(8'($urandom_range(1, 127)));
		end else if (sel < 62) begin
			if ($urandom_range(0, 1))
				cp = PUNCT_CPS[$urandom_range(0, 6)];
			else
				cp = 21'h02010 + 21'($urandom_range(0, 31));
			tok_bytes.push_back({4'b1110, cp[15:12]});
			tok_bytes.push_back({2'b10, cp[11:6]});
			tok_bytes.push_back({2'b10, cp[5:0]});
		end else if (sel < 68) begin
			// stray continuation or invalid lead
			if ($urandom_range(0, 1))
				tok_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
			else
				tok_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
		end else begin
			// multi-byte sequence; the last band is cut short
			len    = (sel < 78) ? 2 : (sel < 86) ? 3 : (sel < 93) ? 4 : $urandom_range(2, 4);
			n_cont = (sel < 93) ? len - 1 : $urandom_range(0, len - 2);
			case (len)
				2:       tok_bytes.push_back({3'b110, 5'($urandom)});
				3:       tok_bytes.push_back({4'b1110, 4'($urandom)});
				default: tok_bytes.push_back({5'b11110, 3'($urandom)});
			endcase
			repeat (n_cont) tok_bytes.push_back({2'b10, 6'($urandom)});
		end
		if ($urandom_range(0, 9) == 0)
			tok_bytes.push_back(8'h00);
	endtask

	// ---------------- main sequence ----------------

	initial begin
		drow_t      dir_tab[$];
		int         ph;
		int         n_sent;
		int         i;
		bit         drained;
		logic [7:0] cap_v;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_byte   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		cap_q     = CAP_RESET;
		clear_string();

		dir_tab = '{
			known_row(8'h41, 2'd1, '{ch: 7'h41, is_end: 1'b0}, NO_ITEM),
			byte_row(8'hE2), byte_row(8'h80), byte_row(8'h98),
			byte_row(8'hE2), byte_row(8'h80), byte_row(8'h9C),
			byte_row(8'hE2), byte_row(8'h80), byte_row(8'h93),
			byte_row(8'hE2), byte_row(8'h80), byte_row(8'hA6),
			byte_row(8'hF0), byte_row(8'h9F), byte_row(8'h98), byte_row(8'h80),
			known_row(8'h80, 2'd0, NO_ITEM, NO_ITEM),
			known_row(8'hFF, 2'd0, NO_ITEM, NO_ITEM),
			byte_row(8'hC3),
			known_row(8'h00, 2'd1, END_ITEM, NO_ITEM),
			cap_row(8'd3),
			byte_row(8'h31),
			known_row(8'h32, 2'd2, '{ch: 7'h32, is_end: 1'b0}, END_ITEM),
			known_row(8'h33, 2'd0, NO_ITEM, NO_ITEM),
			known_row(8'h00, 2'd0, NO_ITEM, NO_ITEM),
			cap_row(8'd1),
			known_row(8'h7A, 2'd1, END_ITEM, NO_ITEM),
			known_row(8'h00, 2'd0, NO_ITEM, NO_ITEM)
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[k]) begin
			if (dir_tab[k].cfg) begin
				wait_idle();
				write_cap(dir_tab[k].val);
			end else begin
				send_byte(dir_tab[k], tx_gap());
			end
		end

		drained = 1'b0;
		for (ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0:       cap_v = 8'd255;
				1:       cap_v = 8'd1;
				2:       cap_v = 8'd2;
				default: cap_v = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
				                                            : 8'($urandom_range(3, 20));
			endcase
			write_cap(cap_v);
			tx_quiet = ($urandom_range(0, 2) == 0);
			rx_quiet = ($urandom_range(0, 2) == 0);
			if (ph == HOLD_PHASE) begin
				// full-rate sender against a held receiver
				tx_quiet  = 1'b1;
				hold_long = 1'b1;
			end
			n_sent = 0;
			while (n_sent < PHASE_ITEMS) begin
				gen_token();
				foreach (tok_bytes[j]) begin
					send_byte(byte_row(tok_bytes[j]), tx_gap());
					n_sent++;
				end
				if (ph == DRAIN_PHASE && !drained && n_sent >= PHASE_ITEMS / 2) begin
					wait_idle();
					drained = 1'b1;
				end
			end
		end

		in_valid <= 1'b0;
		for (i = 0; i < DRAIN_MAX && expected_chars.size() != 0; i++)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (expected_chars.size() != 0) begin
			$display("%0t: %0d expected items never arrived, next ascii_char %h is_end %b",
				$time, expected_chars.size(), expected_chars[0].ch, expected_chars[0].is_end);
			n_fail++;
		end

		if (n_fail == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== utf8_to_ascii_transliterator.f =====
src/u2a_pkg.sv
src/u2a_decode.sv
src/u2a_outq.sv
src/utf8_to_ascii_transliterator.sv
tb/tb.sv
